// ===== design/signed_int_to_radix_digits_assert.svh =====
// assertion macros shared by the radix digit converter
`ifndef SIGNED_INT_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_ASSERT_SVH

// implication checked in the same cycle
`define S2RD_ASSERT_NOW(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// implication checked in the next cycle
`define S2RD_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/s2rd_pkg.sv =====
// shared constants for the radix digit converter
`timescale 1ns / 1ps
`default_nettype none

package s2rd_pkg;

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 5;
  localparam int WORD_W      = 64;
  localparam int REG_IDX_W   = 2;
  localparam int ALPHA_SLOTS = 16;
  localparam int SLOT_W      = 4;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [CHAR_W-1:0]    char_t;

  localparam reg_idx_t REG_BASE_LENGTH   = 2'd0;
  localparam reg_idx_t REG_ALPHABET_LOW  = 2'd1;
  localparam reg_idx_t REG_ALPHABET_HIGH = 2'd2;

  localparam char_t SIGN_CHAR = 8'h2D;
  localparam char_t PLUS_CHAR = 8'h2B;
  localparam char_t NUL_CHAR  = 8'h00;

endpackage

`default_nettype wire

// ===== design/s2rd_if.sv =====
// stream interfaces for numbers in and characters out
`timescale 1ns / 1ps
`default_nettype none

interface s2rd_num_if #(
  parameter int NUMBER_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface s2rd_char_if
  import s2rd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== design/signed_int_to_radix_digits.sv =====
// signed number to text converter with a configurable digit alphabet
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_radix_digits_assert.svh"

// takes one signed number per request on numbers and sends its text on chars,
// one character per request, most significant digit first, with a minus sign
// ahead of negative values and last set on the final digit. the most negative
// value is printed by its true magnitude. the radix is base_length and the
// digits are the first base_length bytes of alphabet_high:alphabet_low (digit
// 0 in the lowest byte). when the alphabet is unusable (radix below 2 or above
// MAX_BASE, a zero, plus or minus byte, or a repeated byte) the number is
// dropped and no character is sent. steps: take the number, check the
// alphabet one character at a time, find each digit in the bit-serial
// restoring divider, send a minus sign if needed, then read each digit
// back from the digit stack and send it, with any wait on chars. the next
// number is taken as soon as the last character sits in the output register.
module signed_int_to_radix_digits
  import s2rd_pkg::*;
#(
  parameter int MAX_BASE     = 16,
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  s2rd_num_if.sink                  numbers,
  s2rd_char_if.source               chars
);

  localparam int RW = $clog2(MAX_BASE);      // digit index width
  localparam int AW = $clog2(NUMBER_WIDTH);  // digit stack / bit counter width

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SIGN  = 6'b001000,
    ST_FETCH = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  // configuration registers
  logic [LEN_W-1:0]  base_length;
  logic [WORD_W-1:0] alphabet_low;
  logic [WORD_W-1:0] alphabet_high;

  state_t                  state;
  logic [NUMBER_WIDTH-1:0] mag;
  logic                    neg;
  logic [RW-1:0]           chk_idx;
  logic [RW-1:0]           rem;
  logic [AW-1:0]           bit_cnt;
  logic [AW-1:0]           nd;
  logic [AW-1:0]           ptr;
  logic [RW-1:0]           rd_digit;
  logic [RW-1:0]           digit_mem [NUMBER_WIDTH];

  // output register
  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  logic [CHAR_W-1:0]       alpha_byte [ALPHA_SLOTS];
  logic [RW:0]             radix;
  logic [RW:0]             trial;
  logic [RW:0]             diff;
  logic                    ge;
  logic [RW-1:0]           rem_next;
  logic [NUMBER_WIDTH-1:0] mag_next;
  logic [CHAR_W-1:0]       chk_char;
  logic                    chk_bad;
  logic                    chk_done;
  logic                    len_ok;
  logic                    slot_free;
  logic                    out_load;
  logic                    in_take;
  logic [NUMBER_WIDTH-1:0] num_raw;

  always_comb begin
    for (int k = 0; k < ALPHA_SLOTS / 2; k++) begin
      alpha_byte[k]                   = alphabet_low[k*CHAR_W +: CHAR_W];
      alpha_byte[k + ALPHA_SLOTS / 2] = alphabet_high[k*CHAR_W +: CHAR_W];
    end
  end

  assign radix    = base_length[RW:0];
  assign len_ok   = (base_length >= LEN_W'(2)) && (base_length <= LEN_W'(MAX_BASE));
  assign slot_free = !out_valid || chars.ready;
  // output register takes a new character this cycle
  assign out_load = ((state == ST_SIGN) || (state == ST_EMIT)) && slot_free;
  assign in_take  = numbers.valid && numbers.ready;
  assign num_raw  = $unsigned(numbers.number);

  // one step of restoring division: bring in the top magnitude bit
  assign trial    = {rem, mag[NUMBER_WIDTH-1]};
  assign ge       = trial >= radix;
  assign diff     = trial - radix;
  assign rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
  assign mag_next = {mag[NUMBER_WIDTH-2:0], ge};

  // alphabet check: one character against every later one per cycle
  always_comb begin
    chk_char = alpha_byte[SLOT_W'(chk_idx)];
    chk_bad  = (chk_char == NUL_CHAR) || (chk_char == SIGN_CHAR) ||
               (chk_char == PLUS_CHAR);
    for (int j = 0; j < MAX_BASE; j++) begin
      if ((j > int'(chk_idx)) && (j < int'(base_length)) &&
          (alpha_byte[j] == chk_char)) begin
        chk_bad = 1'b1;
      end
    end
  end

  assign chk_done = LEN_W'(chk_idx) == (base_length - LEN_W'(1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_length   <= '0;
      alphabet_low  <= '0;
      alphabet_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_LENGTH:   base_length   <= cfg_data[LEN_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHABET_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // digit stack, least significant digit at the bottom
  always_ff @(posedge clk) begin
    if ((state == ST_DIV) && (bit_cnt == AW'(NUMBER_WIDTH - 1))) begin
      digit_mem[nd] <= rem_next;
    end
    if (state == ST_FETCH) begin
      rd_digit <= digit_mem[ptr];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && chars.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            neg     <= num_raw[NUMBER_WIDTH-1];
            mag     <= num_raw[NUMBER_WIDTH-1] ? (~num_raw + NUMBER_WIDTH'(1)) : num_raw;
            chk_idx <= '0;
            // unusable radix drops the number at once
            state   <= len_ok ? ST_CHECK : ST_IDLE;
          end
        end
        ST_CHECK: begin
          if (chk_bad) begin
            state <= ST_IDLE;
          end else if (chk_done) begin
            rem     <= '0;
            bit_cnt <= '0;
            nd      <= '0;
            state   <= ST_DIV;
          end else begin
            chk_idx <= chk_idx + RW'(1);
          end
        end
        ST_DIV: begin
          mag <= mag_next;
          if (bit_cnt == AW'(NUMBER_WIDTH - 1)) begin
            // digit done: quotient now in mag, start the next digit
            rem     <= '0;
            bit_cnt <= '0;
            nd      <= nd + AW'(1);
            if (mag_next == '0) begin
              ptr   <= nd;
              state <= neg ? ST_SIGN : ST_FETCH;
            end
          end else begin
            rem     <= rem_next;
            bit_cnt <= bit_cnt + AW'(1);
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= SIGN_CHAR;
            out_last  <= 1'b0;
            state     <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_char  <= alpha_byte[SLOT_W'(rd_digit)];
            out_last  <= (ptr == '0);
            if (ptr == '0) begin
              state <= ST_IDLE;
            end else begin
              ptr   <= ptr - AW'(1);
              state <= ST_FETCH;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign numbers.ready   = (state == ST_IDLE);
  assign chars.valid     = out_valid;
  assign chars.character = out_char;
  assign chars.last      = out_last;

  `S2RD_ASSERT_NOW(a_rem_below_radix, state == ST_DIV, rem < radix[RW-1:0] || radix[RW], "remainder reached the radix")
  `S2RD_ASSERT_NOW(a_sign_only_neg, state == ST_SIGN, neg, "minus sign state on a non-negative number")
  `S2RD_ASSERT_NOW(a_minus_not_last, out_valid && out_char == SIGN_CHAR, !out_last, "minus sign marked as last")
  `S2RD_ASSERT_NEXT(a_final_digit_last, state == ST_EMIT && slot_free && ptr == '0, out_valid && out_last && state == ST_IDLE, "final digit not marked last")

endmodule

`default_nettype wire

// ===== test/signed_int_to_radix_digits_tb.sv =====
// testbench for the signed number to radix text converter
`timescale 1ns / 1ps

// numbers go in as requests on numbers and come back as text, one character per request on
// chars. a local copy of the three registers predicts the text of every number at the
// edge where its request is taken, and the monitor compares each character against the
// oldest one still owed. registers change only once everything owed has come back.
module signed_int_to_radix_digits_tb;
  import s2rd_pkg::*;

  localparam int NUMBER_WIDTH   = 32;
  localparam int MAX_BASE       = 16;
  localparam int RANDOM_ITEMS   = 80;
  localparam int DROP_PAUSE     = 300;    // covers a number dropped by the alphabet check
  localparam int WATCHDOG_LIMIT = 20000;

  // index 3 is decoded by nobody, writes there must leave everything alone
  localparam reg_idx_t REG_UNUSED = 2'd3;

  typedef logic signed [NUMBER_WIDTH-1:0] number_t;

  typedef struct packed {
    char_t character;
    logic  last;
  } text_char_t;

  typedef enum int {
    FAULT_NONE,
    FAULT_NUL,
    FAULT_PLUS,
    FAULT_SIGN,
    FAULT_REPEAT
  } alphabet_fault_e;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  s2rd_num_if #(.NUMBER_WIDTH(NUMBER_WIDTH)) numbers ();
  s2rd_char_if chars ();

  signed_int_to_radix_digits #(
    .MAX_BASE    (MAX_BASE),
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .numbers  (numbers),
    .chars    (chars)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // our copy of the registers, updated on the edge that writes them
  logic [LEN_W-1:0]  radix_setting;
  logic [WORD_W-1:0] low_digits;
  logic [WORD_W-1:0] high_digits;

  number_t    number_queue[$];    // numbers waiting to be sent
  text_char_t expected_chars[$];  // characters owed by the block, oldest first

  int send_idle_pct;
  int recv_idle_pct;
  int send_gap;
  int recv_stall;
  int quiet_cycles;
  int mismatch_count;
  int numbers_taken;
  int numbers_rendered;
  int chars_checked;
  int reg_writes;
  text_char_t oldest;

  // gap length: mostly none, then short, now and then long
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic char_t digit_byte(int unsigned idx);
    logic [2*WORD_W-1:0] both;
    both = {high_digits, low_digits};
    return both[idx*8 +: 8];
  endfunction

  // radix within 2..MAX_BASE, no nul, plus or minus byte, no byte twice
  function automatic bit alphabet_usable();
    char_t c;
    if (radix_setting < 2 || radix_setting > MAX_BASE) return 1'b0;
    for (int i = 0; i < radix_setting; i++) begin
      c = digit_byte(i);
      if (c == NUL_CHAR || c == PLUS_CHAR || c == SIGN_CHAR) return 1'b0;
      for (int j = i + 1; j < radix_setting; j++) begin
        if (digit_byte(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // text of one number under the current registers, queued for the monitor
  function automatic void render_number(number_t value);
    logic [NUMBER_WIDTH-1:0] mag;
    int unsigned digits[$];
    if (!alphabet_usable()) return;
    numbers_rendered++;
    // unsigned negation, so the most negative value keeps its true magnitude
    mag = value[NUMBER_WIDTH-1] ? ~value + 1'b1 : value;
    do begin
      digits.push_back(mag % radix_setting);
      mag = mag / radix_setting;
    end while (mag != 0);
    if (value[NUMBER_WIDTH-1]) expected_chars.push_back('{SIGN_CHAR, 1'b0});
    for (int k = digits.size() - 1; k >= 0; k--) begin
      expected_chars.push_back('{digit_byte(digits[k]), k == 0});
    end
  endfunction

  // random alphabet of len distinct usable bytes, unused slots hold anything,
  // optionally spoiled in one slot in use
  function automatic void make_alphabet(input int len, input alphabet_fault_e fault,
                                        output logic [WORD_W-1:0] lo,
                                        output logic [WORD_W-1:0] hi);
    char_t               slots[ALPHA_SLOTS];
    logic [2*WORD_W-1:0] packed_slots;
    char_t               c;
    bit                  clash;
    int                  k;
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      if (i < len) begin
        do begin
          c = char_t'($urandom_range(1, 255));
          clash = (c == SIGN_CHAR) || (c == PLUS_CHAR);
          for (int j = 0; j < i; j++) begin
            if (slots[j] == c) clash = 1'b1;
          end
        end while (clash);
      end else begin
        c = char_t'($urandom_range(0, 255));
      end
      slots[i] = c;
    end
    k = $urandom_range(0, len - 1);
    case (fault)
      FAULT_NUL:    slots[k] = NUL_CHAR;
      FAULT_PLUS:   slots[k] = PLUS_CHAR;
      FAULT_SIGN:   slots[k] = SIGN_CHAR;
      FAULT_REPEAT: slots[k] = slots[(k + 1 + $urandom_range(0, len - 2)) % len];
      default: ;
    endcase
    for (int i = 0; i < ALPHA_SLOTS; i++) packed_slots[i*8 +: 8] = slots[i];
    {hi, lo} = packed_slots;
  endfunction

  // number: mostly full width, some small magnitudes, some extremes
  function automatic number_t pick_number();
    number_t mag;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5: begin
        mag = $urandom_range(0, 40);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      6: begin
        mag = $urandom_range(0, 1 << $urandom_range(0, 30));
        return $urandom_range(0, 1) ? -mag : mag;
      end
      7: return {1'b1, {(NUMBER_WIDTH-1){1'b0}}};
      8: return {1'b0, {(NUMBER_WIDTH-1){1'b1}}};
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [WORD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      REG_BASE_LENGTH:   radix_setting = value[LEN_W-1:0];
      REG_ALPHABET_LOW:  low_digits    = value;
      REG_ALPHABET_HIGH: high_digits   = value;
      default: ;
    endcase
  endtask

  task automatic load_alphabet(logic [WORD_W-1:0] len_word, logic [WORD_W-1:0] lo,
                               logic [WORD_W-1:0] hi);
    write_reg(REG_ALPHABET_LOW, lo);
    write_reg(REG_ALPHABET_HIGH, hi);
    write_reg(REG_BASE_LENGTH, len_word);
  endtask

  // everything sent and answered, then time for a number that was silently dropped
  task automatic drain_and_pause();
    do @(negedge clk);
    while (number_queue.size() != 0 || numbers.valid || expected_chars.size() != 0);
    repeat (DROP_PAUSE) @(negedge clk);
  endtask

  // number side: predict on every taken request, then pick the next number or a gap
  always @(posedge clk) begin
    if (rst) begin
      numbers.valid  <= 1'b0;
      numbers.number <= '0;
      send_gap       <= 0;
    end else begin
      if (numbers.valid && numbers.ready) begin
        numbers_taken++;
        render_number(numbers.number);
      end
      if (!numbers.valid || numbers.ready) begin
        if (send_gap != 0) begin
          numbers.valid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (number_queue.size() != 0) begin
          numbers.valid  <= 1'b1;
          numbers.number <= number_queue.pop_front();
          send_gap       <= pick_gap(send_idle_pct);
        end else begin
          numbers.valid <= 1'b0;
        end
      end
    end
  end

  // character side: random back-pressure, every taken request checked in order
  always @(posedge clk) begin
    if (rst) begin
      chars.ready <= 1'b0;
      recv_stall  <= 0;
    end else begin
      if (chars.valid && chars.ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected character %02h last %0b", chars.character, chars.last);
          mismatch_count++;
        end else begin
          oldest = expected_chars.pop_front();
          if (chars.character !== oldest.character || chars.last !== oldest.last) begin
            if (mismatch_count < 10)
              $display("character mismatch: expected %02h last %0b, got %02h last %0b",
                       oldest.character, oldest.last, chars.character, chars.last);
            mismatch_count++;
          end
        end
      end
      if (recv_stall != 0) begin
        chars.ready <= 1'b0;
        recv_stall  <= recv_stall - 1;
      end else begin
        chars.ready <= 1'b1;
        recv_stall  <= pick_gap(recv_idle_pct);
      end
    end
  end

  // no request taken on either side for too long
  always @(posedge clk) begin
    if (rst || (numbers.valid && numbers.ready) || (chars.valid && chars.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               phase_items;
    int               len;
    int               random_start;
    alphabet_fault_e  fault;
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;

    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    numbers.valid    = 1'b0;
    numbers.number   = '0;
    chars.ready      = 1'b0;
    radix_setting    = '0;
    low_digits       = '0;
    high_digits      = '0;
    send_idle_pct    = 20;
    recv_idle_pct    = 20;
    mismatch_count   = 0;
    numbers_taken    = 0;
    numbers_rendered = 0;
    chars_checked    = 0;
    reg_writes       = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: radix 0, the number must vanish
    number_queue.push_back(-7);
    drain_and_pause();

    // decimal, with the edges of the number range
    load_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
    number_queue = '{0, 1, -1, 10, -10, 32'sh7FFF_FFFF, 32'sh8000_0000};
    drain_and_pause();

    // radix 16 with the extreme digit bytes 0x01 and 0xff
    load_alphabet(64'd16, 64'h0706_0504_0302_01FF, 64'h0F0E_0D0C_0B0A_0908);
    number_queue = '{0, -1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678};
    drain_and_pause();

    // binary, unused slots full of bytes that would be illegal if in use
    load_alphabet(64'd2, 64'h2D2B_00FF_2D2B_3130, '1);
    number_queue = '{0, -1, 32'sh8000_0000, 6};
    drain_and_pause();

    // radix above the slot count, junk in the upper data bits of the write
    write_reg(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
    number_queue.push_back($urandom);
    drain_and_pause();
    write_reg(REG_BASE_LENGTH, 64'h1F);
    number_queue.push_back($urandom);
    drain_and_pause();

    // radix 1
    load_alphabet(64'd1, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
    number_queue.push_back(5);
    drain_and_pause();

    // a nul, a plus, a minus in use, then every byte the same
    load_alphabet(64'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_0061_3938);
    number_queue.push_back(5);
    drain_and_pause();
    write_reg(REG_ALPHABET_HIGH, 64'h6665_6463_6261_2B38);
    number_queue.push_back(5);
    drain_and_pause();
    write_reg(REG_ALPHABET_HIGH, 64'h2D65_6463_6261_3938);
    number_queue.push_back(5);
    drain_and_pause();
    load_alphabet(64'd8, '1, '1);
    number_queue.push_back(5);
    drain_and_pause();

    // back to decimal, then a write to the undecoded index must change nothing
    load_alphabet(64'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);
    write_reg(REG_UNUSED, '1);
    number_queue.push_back(-42);
    drain_and_pause();

    // random settings: mostly usable alphabets, some spoiled ones
    random_start = numbers_rendered;
    while (numbers_rendered - random_start < RANDOM_ITEMS) begin
      len   = $urandom_range(2, MAX_BASE);
      fault = FAULT_NONE;
      case ($urandom_range(0, 9))
        8: fault = alphabet_fault_e'($urandom_range(FAULT_NUL, FAULT_REPEAT));
        9: len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
        default: ;
      endcase
      make_alphabet((len < 2 || len > MAX_BASE) ? MAX_BASE : len, fault, lo, hi);
      load_alphabet({{(WORD_W-LEN_W){1'b0}}, LEN_W'(len)} | ({$urandom, $urandom} << LEN_W),
                    lo, hi);
      // some settings run with no idling at all
      send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
      recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
      phase_items   = $urandom_range(6, 14);
      repeat (phase_items) number_queue.push_back(pick_number());
      drain_and_pause();
    end

    $display("sent %0d numbers through %0d register writes, %0d of them with a usable alphabet",
             numbers_taken, reg_writes, numbers_rendered);
    $display("checked %0d characters, %0d mismatches", chars_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/s2rd_pkg.sv
design/s2rd_if.sv
design/signed_int_to_radix_digits.sv
test/signed_int_to_radix_digits_tb.sv
